// ----- src/linear_probing_hash_table_defines.svh -----
// assertion macros for the hash table block
// used by the top level only, no other dependencies
`ifndef LINEAR_PROBING_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LPHT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

// ----- src/lpht_pkg.sv -----
// shared types and constants for the linear probing hash table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam status_type STATUS_INSERTED  = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_FOUND     = 2'd2;
   localparam status_type STATUS_NOT_FOUND = 2'd3;

   // one table slot as stored in the memory
   typedef struct packed {
      logic    used;
      key_type key;
   } slot_type;

endpackage

`default_nettype wire

// ----- src/lpht_if.sv -----
// valid/ready channel interfaces for request and response beats
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   lpht_pkg::key_type key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

interface lpht_rsp_if;
   logic                 valid;
   logic                 ready;
   lpht_pkg::status_type status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// ----- src/lpht_mod_unit.sv -----
// remainder unit: key modulo TABLE_SIZE by reciprocal multiplication on one shared multiplier
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod_unit #(
   parameter int TABLE_SIZE = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire lpht_pkg::key_type             key,
   output      logic                          busy,
   output      logic                          done,
   output      logic [$clog2(TABLE_SIZE)-1:0] rem
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int SHIFT = lpht_pkg::KEY_W + IDX_W;
   // ceil(2^SHIFT / TABLE_SIZE) gives an exact quotient for every 31-bit key
   localparam logic [63:0] NUMER_C = 64'd1 << SHIFT;
   localparam logic [31:0] RECIP_C =
      32'((NUMER_C + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
   localparam logic [31:0] SIZE_C  = 32'(TABLE_SIZE);

   localparam logic [1:0] STEP_SCALE = 2'd0;
   localparam logic [1:0] STEP_BACK  = 2'd1;
   localparam logic [1:0] STEP_SUB   = 2'd2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [1:0]           step_ff, step_in;
   lpht_pkg::key_type    key_ff, key_in;
   logic [63:0]          prod_ff, prod_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   lpht_pkg::key_type    quo;
   lpht_pkg::key_type    diff;
   lpht_pkg::key_type    mul_a;
   logic [31:0]          mul_b;
   logic [63:0]          mul_p;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      key_in  = key_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      quo     = lpht_pkg::key_type'(prod_ff >> SHIFT);
      diff    = key_ff - lpht_pkg::key_type'(prod_ff);
      // one multiplier: key times reciprocal, then quotient times table size
      if (step_ff == STEP_SCALE) begin
         mul_a = key_ff;
         mul_b = RECIP_C;
      end else begin
         mul_a = quo;
         mul_b = SIZE_C;
      end
      mul_p = 64'(mul_a) * 64'(mul_b);
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_SCALE;
         key_in  = key;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_SCALE: begin
               prod_in = mul_p;
               step_in = STEP_BACK;
            end
            STEP_BACK: begin
               prod_in = mul_p;
               step_in = STEP_SUB;
            end
            STEP_SUB: begin
               rem_in  = IDX_W'(diff);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ----- src/lpht_slot_mem.sv -----
// slot memory: one write port, one read port with registered read data
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_slot_mem #(
   parameter int TABLE_SIZE = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  wire lpht_pkg::slot_type            wr_data,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output      lpht_pkg::slot_type            rd_data
);

   lpht_pkg::slot_type mem [TABLE_SIZE];
   lpht_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/linear_probing_hash_table.sv -----
// Linear probing hash table of TABLE_SIZE slots. Each request beat is an insert
// (func 0) or a search (func 1) of a 31-bit key; each gives exactly one response
// beat with its status. After reset the block sweeps the slot memory, one slot a
// cycle, and accepts no request until the sweep is done. One request is worked at
// a time: the home slot comes from a remainder unit that runs a reciprocal
// multiply and a multiply-back on one shared multiplier, then the probe reads one
// slot per cycle from the single read port of the slot memory, whose read data is
// registered. A request looks at k slots (1 <= k <= TABLE_SIZE) before its status
// is known. The next request is taken only after the current response has been
// registered, and an earlier response still held by back-pressure delays that.
// depends on lpht_pkg, lpht_if, lpht_mod_unit, lpht_slot_mem and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probing_hash_table_defines.svh"

module linear_probing_hash_table #(
   parameter int TABLE_SIZE = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   lpht_req_if.sink   req_ch,
   lpht_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      chk_pos_ff, chk_pos_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      probe_cnt_ff, probe_cnt_in;
   logic                  func_ff, func_in;
   lpht_pkg::key_type     key_ff, key_in;
   lpht_pkg::status_type  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  req_beat;
   logic                  mod_busy;
   logic                  mod_done;
   logic [IDX_W-1:0]      mod_rem;
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   lpht_pkg::slot_type    mem_wr_data;
   lpht_pkg::slot_type    mem_rd_data;
   logic [IDX_W-1:0]      pos_next;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_beat      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign pos_next      = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;

   lpht_mod_unit #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (req_beat),
      .key   (req_ch.key),
      .busy  (mod_busy),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   lpht_slot_mem #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      chk_pos_in    = chk_pos_ff;
      chk_vld_in    = 1'b0;
      probe_cnt_in  = probe_cnt_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pos_ff;
      mem_wr_data   = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            pos_in    = pos_next;
            if (pos_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               func_in  = req_ch.func;
               key_in   = req_ch.key;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               pos_in       = mod_rem;
               probe_cnt_in = '0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // a read goes out every cycle; its data comes back in the next cycle
            pos_in     = pos_next;
            chk_pos_in = pos_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (!mem_rd_data.used) begin
                  if (func_ff == lpht_pkg::FUNC_INSERT) begin
                     mem_wr_en        = 1'b1;
                     mem_wr_addr      = chk_pos_ff;
                     mem_wr_data.used = 1'b1;
                     mem_wr_data.key  = key_ff;
                     status_in        = lpht_pkg::STATUS_INSERTED;
                  end else begin
                     status_in = lpht_pkg::STATUS_NOT_FOUND;
                  end
                  state_in = ST_DONE;
               end else if (func_ff == lpht_pkg::FUNC_SEARCH
                            && mem_rd_data.key == key_ff) begin
                  status_in = lpht_pkg::STATUS_FOUND;
                  state_in  = ST_DONE;
               end else if (probe_cnt_ff == LAST_IDX) begin
                  // every slot looked at and occupied
                  status_in = (func_ff == lpht_pkg::FUNC_INSERT)
                              ? lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOT_FOUND;
                  state_in  = ST_DONE;
               end else begin
                  probe_cnt_in = probe_cnt_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_pos_ff    <= chk_pos_in;
      probe_cnt_ff  <= probe_cnt_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   `LPHT_ASSERT_NEXT(a_beat_starts_mod, clock, reset, req_beat, mod_busy && state_ff == ST_MOD)
   `LPHT_ASSERT_SAME(a_mod_done_in_mod, clock, reset, mod_done, state_ff == ST_MOD)
   `LPHT_ASSERT_SAME(a_insert_only_empty, clock, reset,
      state_ff == ST_PROBE && mem_wr_en, chk_vld_ff && !mem_rd_data.used)
   `LPHT_ASSERT_SAME(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

`default_nettype wire

// ----- tb/linear_probing_hash_table_test.sv -----
// testbench for linear_probing_hash_table: directed and random insert/search beats,
// checked against a slot-level predictor kept in a small scoreboard class
// depends on lpht_pkg, lpht_if and the linear_probing_hash_table top level
`timescale 1ns / 1ps

module linear_probing_hash_table_test;

   localparam int TABLE_SIZE  = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BEATS = 1900;
   localparam lpht_pkg::key_type KEY_MAX = {lpht_pkg::KEY_W{1'b1}};

   class lookup_scoreboard;
      logic                 slot_used [TABLE_SIZE];
      lpht_pkg::key_type    slot_key [TABLE_SIZE];
      lpht_pkg::status_type status_due [$];
      int                   errors;

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
         end
         errors = 0;
      endfunction

      // walks the probe sequence and updates the slots on a successful insert
      function lpht_pkg::status_type probe_status(logic func, lpht_pkg::key_type key);
         int pos;
         pos = int'(key % TABLE_SIZE);
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (func == lpht_pkg::FUNC_INSERT) begin
               if (!slot_used[pos]) begin
                  slot_used[pos] = 1'b1;
                  slot_key[pos]  = key;
                  return lpht_pkg::STATUS_INSERTED;
               end
            end else begin
               // an empty slot never matches, whatever key it holds
               if (!slot_used[pos])
                  return lpht_pkg::STATUS_NOT_FOUND;
               if (slot_key[pos] == key)
                  return lpht_pkg::STATUS_FOUND;
            end
            pos = (pos + 1) % TABLE_SIZE;
         end
         return (func == lpht_pkg::FUNC_INSERT) ? lpht_pkg::STATUS_FULL
                                                : lpht_pkg::STATUS_NOT_FOUND;
      endfunction

      function void note_request(logic func, lpht_pkg::key_type key);
         status_due.push_back(probe_status(func, key));
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(lpht_pkg::status_type got);
         lpht_pkg::status_type want;
         if (status_due.size() == 0) begin
            report($sformatf("response beat with status %0d and nothing pending", got));
         end else begin
            want = status_due.pop_front();
            if (got !== want)
               report($sformatf("status %0d, predicted %0d", got, want));
         end
      endtask

      function int pending();
         return status_due.size();
      endfunction

      function lpht_pkg::key_type stored_key(int idx);
         return slot_key[idx];
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   src_quiet;
   bit   snk_quiet;
   int   stall_count;

   lpht_req_if req_ch ();
   lpht_rsp_if rsp_ch ();

   lookup_scoreboard board;

   linear_probing_hash_table #(.TABLE_SIZE(TABLE_SIZE)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int idle_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic lpht_pkg::key_type random_key();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return '0;
         1: return KEY_MAX;
         2: return lpht_pkg::key_type'($urandom_range(0, 63));
         default: return lpht_pkg::key_type'($urandom);
      endcase
   endfunction

   task automatic send_beat(logic func, lpht_pkg::key_type key);
      int gap;
      gap = idle_gap(src_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.key   <= key;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // both handshakes sampled on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         stall_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.status);
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.func, req_ch.key);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            stall_count <= 0;
         else
            stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // response side: random back-pressure before each beat
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 59) == 0)
            snk_quiet = ~snk_quiet;
         gap = idle_gap(snk_quiet);
         repeat (gap) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      int                pick;
      lpht_pkg::key_type fill_key;
      lpht_pkg::key_type last_fill;
      board        = new();
      req_ch.valid = 1'b0;
      req_ch.func  = lpht_pkg::FUNC_INSERT;
      req_ch.key   = '0;
      src_quiet    = 1'b0;
      reset        = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: stored zero keys must not match
      send_beat(lpht_pkg::FUNC_SEARCH, '0);
      send_beat(lpht_pkg::FUNC_INSERT, KEY_MAX);
      // home slot is the last one, so this wraps to slot 0
      send_beat(lpht_pkg::FUNC_INSERT, lpht_pkg::key_type'(15));
      send_beat(lpht_pkg::FUNC_SEARCH, lpht_pkg::key_type'(15));
      send_beat(lpht_pkg::FUNC_SEARCH, lpht_pkg::key_type'(31));
      send_beat(lpht_pkg::FUNC_INSERT, '0);
      // duplicate key
      send_beat(lpht_pkg::FUNC_INSERT, '0);
      send_beat(lpht_pkg::FUNC_SEARCH, '0);
      send_beat(lpht_pkg::FUNC_SEARCH, KEY_MAX);
      send_beat(lpht_pkg::FUNC_SEARCH, lpht_pkg::key_type'(16));
      // fill the rest with one colliding cluster
      last_fill = '0;
      for (int i = 0; i < TABLE_SIZE - 4; i++) begin
         fill_key = (lpht_pkg::key_type'($urandom) & ~lpht_pkg::key_type'(15))
                    | lpht_pkg::key_type'(3);
         send_beat(lpht_pkg::FUNC_INSERT, fill_key);
         last_fill = fill_key;
      end
      // full table cases
      send_beat(lpht_pkg::FUNC_INSERT, lpht_pkg::key_type'(5));
      send_beat(lpht_pkg::FUNC_SEARCH, lpht_pkg::key_type'(32'h5555_5555));
      send_beat(lpht_pkg::FUNC_SEARCH, last_fill);
      wait_drained();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if ($urandom_range(0, 59) == 0)
            src_quiet = ~src_quiet;
         if (i == RANDOM_BEATS / 2)
            wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 40)
            send_beat(lpht_pkg::FUNC_SEARCH,
                      board.stored_key($urandom_range(0, TABLE_SIZE - 1)));
         else if (pick < 70)
            send_beat(lpht_pkg::FUNC_SEARCH, random_key());
         else
            send_beat(lpht_pkg::FUNC_INSERT, random_key());
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
